@@ hdl/lrl_pkg.sv @@
`timescale 1ns / 1ps

package lrl_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 16;
	localparam int COUNT_OUT_W   = 5;

	// operation codes; code 3 is a no-op
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_VICTIM = 2'd1;
	localparam logic [1:0] FUNC_ERASE  = 2'd2;

	typedef enum logic [1:0] {
		STATUS_DONE = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	// per-cycle shift command broadcast to every cell
	typedef struct packed {
		logic shift_in_all;   // new key: whole row moves one slot back
		logic shift_in_hit;   // touch: slots up to the hit move back
		logic shift_out_hit;  // erase: slots from the hit move forward
	} ctrl_t;

endpackage

@@ hdl/lru_replacement_list_top.sv @@
`timescale 1ns / 1ps

// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------------------
// in      | in_valid  | in_stall  | func, key
// out     | out_valid | out_stall | status, victim_key, entry_count
//
// One item per cycle: the row of cells compares all slots at once and
// shifts in the same edge; the result lands in the output register.
// Throughput is set by the output register: a new item is taken only when
// the output register is empty or being drained that cycle.
// Reset clears the count and the output valid; slot contents are don't-care.
// in_stall is high exactly while a result waits under out_stall.

module lru_replacement_list_top #(
	parameter int CAPACITY  = lrl_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = lrl_pkg::KEY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [KEY_WIDTH-1:0]            key,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [KEY_WIDTH-1:0]            victim_key,
	output logic [lrl_pkg::COUNT_OUT_W-1:0] entry_count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// row state
	logic [CNT_W-1:0]     count_q;
	logic [KEY_WIDTH-1:0] slot   [CAPACITY];
	logic [KEY_WIDTH-1:0] vict_c [CAPACITY+1];
	logic [CAPACITY:0]    hit_c;
	logic [CAPACITY-1:0]  match_v;
	logic [CAPACITY-1:0]  occ_v;
	logic [CAPACITY-1:0]  last_v;

	// output register
	logic                 out_valid_q;
	lrl_pkg::status_t     status_q;
	logic [KEY_WIDTH-1:0] victim_q;
	logic [CNT_W-1:0]     out_cnt_q;

	// decode
	logic                 take;
	logic                 any_hit;
	logic                 full;
	lrl_pkg::ctrl_t       ctrl_d;
	lrl_pkg::ctrl_t       ctrl;
	lrl_pkg::status_t     status_d;
	logic [KEY_WIDTH-1:0] victim_d;
	logic [CNT_W-1:0]     count_d;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign any_hit  = hit_c[CAPACITY];
	assign full     = (count_q == CNT_W'(CAPACITY));

	assign hit_c[0]  = 1'b0;
	assign vict_c[0] = '0;

	// the cell chain: slot 0 is most recent, slot count-1 least recent
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_key;
		logic [KEY_WIDTH-1:0] right_key;

		assign occ_v[i]  = (count_q > CNT_W'(i));
		assign last_v[i] = (count_q == CNT_W'(i + 1));

		if (i == 0) begin : g_head
			assign left_key = key;
		end else begin : g_body
			assign left_key = slot[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_key = slot[i];
		end else begin : g_inner
			assign right_key = slot[i+1];
		end

		lrl_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk      (clk),
			.query    (key),
			.left_key (left_key),
			.right_key(right_key),
			.occ      (occ_v[i]),
			.last     (last_v[i]),
			.hit_in   (hit_c[i]),
			.vict_in  (vict_c[i]),
			.ctrl     (ctrl),
			.slot     (slot[i]),
			.match    (match_v[i]),
			.hit_out  (hit_c[i+1]),
			.vict_out (vict_c[i+1])
		);
	end

	// operation decode; a touch of a held key works even when full
	always_comb begin
		ctrl_d   = '0;
		status_d = lrl_pkg::STATUS_DONE;
		victim_d = '0;
		count_d  = count_q;
		unique case (func)
			lrl_pkg::FUNC_INSERT: begin
				if (any_hit) begin
					ctrl_d.shift_in_hit = 1'b1;
				end else if (full) begin
					status_d = lrl_pkg::STATUS_FULL;
				end else begin
					ctrl_d.shift_in_all = 1'b1;
					count_d             = count_q + CNT_W'(1);
				end
			end
			lrl_pkg::FUNC_VICTIM: begin
				if (count_q == '0) begin
					status_d = lrl_pkg::STATUS_MISS;
				end else begin
					victim_d = vict_c[CAPACITY];
					count_d  = count_q - CNT_W'(1);
				end
			end
			lrl_pkg::FUNC_ERASE: begin
				if (any_hit) begin
					ctrl_d.shift_out_hit = 1'b1;
					count_d              = count_q - CNT_W'(1);
				end else begin
					status_d = lrl_pkg::STATUS_MISS;
				end
			end
			default: begin
				// no-op code
			end
		endcase
	end

	assign ctrl = take ? ctrl_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q  <= status_d;
			victim_q  <= victim_d;
			out_cnt_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign victim_key  = victim_q;
	assign entry_count = lrl_pkg::COUNT_OUT_W'(out_cnt_q);

	// keys are distinct, so at most one cell matches
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_v))
		else $error("more than one slot holds the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		take && (func == lrl_pkg::FUNC_INSERT) && !any_hit && full
		|=> (count_q == CNT_W'(CAPACITY)) && (status_q == lrl_pkg::STATUS_FULL))
		else $error("insert into full list not refused");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q && (out_cnt_q == count_q))
		else $error("result missing or count mismatch");

endmodule

@@ hdl/lrl_cell.sv @@
`timescale 1ns / 1ps

module lrl_cell #(
	parameter int KEY_WIDTH = lrl_pkg::KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic [KEY_WIDTH-1:0] query,
	input  logic [KEY_WIDTH-1:0] left_key,
	input  logic [KEY_WIDTH-1:0] right_key,
	input  logic                 occ,
	input  logic                 last,
	input  logic                 hit_in,
	input  logic [KEY_WIDTH-1:0] vict_in,
	input  lrl_pkg::ctrl_t       ctrl,
	output logic [KEY_WIDTH-1:0] slot,
	output logic                 match,
	output logic                 hit_out,
	output logic [KEY_WIDTH-1:0] vict_out
);

	logic [KEY_WIDTH-1:0] slot_q;
	logic                 hit_incl;
	logic                 load_left;
	logic                 load_right;

	// hit_in: the key sits in an earlier slot; hit_incl: here or earlier
	assign match      = occ && (slot_q == query);
	assign hit_incl   = hit_in | match;
	assign hit_out    = hit_incl;
	assign load_left  = ctrl.shift_in_all | (ctrl.shift_in_hit & !hit_in);
	assign load_right = ctrl.shift_out_hit & hit_incl;
	assign vict_out   = vict_in | ({KEY_WIDTH{last}} & slot_q);
	assign slot       = slot_q;

	always_ff @(posedge clk) begin
		if (load_left) begin
			slot_q <= left_key;
		end else if (load_right) begin
			slot_q <= right_key;
		end
	end

endmodule

@@ sim/lru_replacement_list_top_tb.sv @@
`timescale 1ns / 1ps

// Checks the LRU replacement list: a behavioral copy of the list runs beside
// the block. Each accepted item is applied to the copy. The result that the
// copy produces is queued and compared with the block's next accepted result.
// Directed items cover the empty list, key extremes, the full list and the
// unused op code. Random traffic from a small key pool drives the list into
// hits, refusals and drains. Both sides idle at random. One phase has no
// idling at all. A long output hold backs the block up. One phase waits for
// the list to go quiet between bursts.

module lru_replacement_list_top_tb;

	localparam int KW       = lrl_pkg::KEY_WIDTH_DEF;
	localparam int CAP      = lrl_pkg::CAPACITY_DEF;
	localparam int CW       = lrl_pkg::COUNT_OUT_W;
	localparam int POOL_SZ  = 24;
	localparam int IDLE_PCT = 28;

	// unused op code: the block treats it as a no-op
	localparam logic [1:0] FUNC_NOP = 2'd3;

	typedef struct {
		lrl_pkg::status_t status;
		logic [KW-1:0]    victim_key;
		logic [CW-1:0]    entry_count;
	} lru_result_t;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	logic [1:0]     func;
	logic [KW-1:0]  key;
	logic           out_valid;
	logic           out_stall;
	logic [1:0]     status;
	logic [KW-1:0]  victim_key;
	logic [CW-1:0]  entry_count;

	// shadow of the block's list, front = most recently used
	logic [KW-1:0]  recency_list[$];
	lru_result_t    expected_results[$];
	logic [KW-1:0]  key_pool[POOL_SZ];

	int  fail_count = 0;
	bit  gaps_on    = 1'b1;  // random idling on both channels
	int  hold_left  = 0;     // receiver hold-off, in cycles

	lru_replacement_list_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.key         (key),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.victim_key  (victim_key),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous bound: ~1300 items with idling on both sides finish well before the timeout
	initial begin
		#2_000_000;
		$display("lru_replacement_list_top_tb NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow list
	// ------------------------------------------------------------------

	function automatic int find_key(logic [KW-1:0] k);
		for (int i = 0; i < recency_list.size(); i++)
			if (recency_list[i] == k)
				return i;
		return -1;
	endfunction

	// applies one op to the shadow list and returns the result it gives
	function automatic lru_result_t lru_predict(logic [1:0] op, logic [KW-1:0] k);
		lru_result_t r;
		int          pos;
		r.status     = lrl_pkg::STATUS_DONE;
		r.victim_key = '0;
		case (op)
			lrl_pkg::FUNC_INSERT: begin
				// a touch removes the old copy first, so it never hits the full case
				pos = find_key(k);
				if (pos >= 0)
					recency_list.delete(pos);
				if (recency_list.size() >= CAP)
					r.status = lrl_pkg::STATUS_FULL;
				else
					recency_list.insert(0, k);
			end
			lrl_pkg::FUNC_VICTIM: begin
				if (recency_list.size() == 0) begin
					r.status = lrl_pkg::STATUS_MISS;
				end else begin
					r.victim_key = recency_list[recency_list.size() - 1];
					recency_list.delete(recency_list.size() - 1);
				end
			end
			lrl_pkg::FUNC_ERASE: begin
				pos = find_key(k);
				if (pos < 0)
					r.status = lrl_pkg::STATUS_MISS;
				else
					recency_list.delete(pos);
			end
			default: ;  // no-op
		endcase
		r.entry_count = CW'(recency_list.size());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input channel
	// ------------------------------------------------------------------

	// Offers one item and returns at the edge that accepts it. Valid stays
	// high afterwards so back-to-back items need no drop; callers that stop
	// sending go through release_input.
	task automatic send_item(logic [1:0] op, logic [KW-1:0] k);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func     = op;
		key      = k;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(lru_predict(op, k));
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// sender pause: nothing offered until every result is back
	task automatic wait_for_drain();
		release_input();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KW-1:0] pick_key();
		if ($urandom_range(99) < 80)
			return key_pool[$urandom_range(POOL_SZ - 1)];
		return KW'($urandom);
	endfunction

	// random ops, inserts weighted by insert_pct; the rest split victim/erase/nop
	task automatic send_random_ops(int n, int insert_pct);
		int          roll;
		logic [1:0]  op;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < insert_pct)
				op = lrl_pkg::FUNC_INSERT;
			else if (roll < insert_pct + (95 - insert_pct) / 2)
				op = lrl_pkg::FUNC_VICTIM;
			else if (roll < 95)
				op = lrl_pkg::FUNC_ERASE;
			else
				op = FUNC_NOP;
			send_item(op, pick_key());
		end
	endtask

	// ------------------------------------------------------------------
	// Output channel: random stall plus a counted hold-off
	// ------------------------------------------------------------------

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// result check: every accepted result against the oldest expectation
	always @(posedge clk) begin
		lru_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: status %0d victim_key %h count %0d",
					status, victim_key, entry_count);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					fail_count++;
				end
				if (victim_key !== exp_r.victim_key) begin
					$error("victim_key: expected %h, got %h", exp_r.victim_key, victim_key);
					fail_count++;
				end
				if (entry_count !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						exp_r.entry_count, entry_count);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// victim, erase and no-op on an empty list
	task automatic test_empty_list();
		send_item(lrl_pkg::FUNC_VICTIM, 16'h1234);
		send_item(lrl_pkg::FUNC_ERASE, 16'h0000);
		send_item(FUNC_NOP, 16'hFFFF);
	endtask

	task automatic test_key_extremes();
		send_item(lrl_pkg::FUNC_INSERT, 16'h0000);
		send_item(lrl_pkg::FUNC_INSERT, 16'hFFFF);
		send_item(lrl_pkg::FUNC_INSERT, 16'h0000);  // touch: zero back to the front
		send_item(lrl_pkg::FUNC_ERASE, 16'hFFFF);
		send_item(lrl_pkg::FUNC_ERASE, 16'h5A5A);   // not held
		send_item(lrl_pkg::FUNC_VICTIM, 16'hFFFF);  // key field ignored
		send_item(lrl_pkg::FUNC_VICTIM, 16'h0000);  // now empty again
	endtask

	// fill to capacity, then refusal of a new key and touch of a held one
	task automatic test_full_list();
		for (int i = 0; i < CAP; i++)
			send_item(lrl_pkg::FUNC_INSERT, 16'hA000 | KW'(i));
		send_item(lrl_pkg::FUNC_INSERT, 16'h5555);  // new key while full: refused
		send_item(lrl_pkg::FUNC_INSERT, 16'hA003);  // held key while full: moved up
		send_item(FUNC_NOP, 16'hA000);
		send_item(lrl_pkg::FUNC_ERASE, 16'hA007);
		send_item(lrl_pkg::FUNC_VICTIM, 16'h0000);  // oldest: first key filled
		send_item(lrl_pkg::FUNC_INSERT, 16'h5555);  // room again
	endtask

	task automatic test_random_traffic();
		send_random_ops(800, 55);
	endtask

	// more victims and erases, so the list spends time near empty
	task automatic test_drain_heavy();
		send_random_ops(200, 25);
	endtask

	task automatic test_back_to_back();
		wait_for_drain();
		gaps_on = 1'b0;
		send_random_ops(150, 50);
		wait_for_drain();
		gaps_on = 1'b1;
	endtask

	// receiver holds off long enough that the block backs up and stalls input
	task automatic test_output_hold();
		hold_left = 80;
		send_random_ops(60, 50);
	endtask

	task automatic test_sender_pause();
		for (int r = 0; r < 3; r++) begin
			send_random_ops(30, 55);
			wait_for_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		func     = lrl_pkg::FUNC_INSERT;
		key      = '0;
		foreach (key_pool[i])
			key_pool[i] = KW'($urandom);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_key_extremes();
		test_full_list();
		test_random_traffic();
		test_drain_heavy();
		test_back_to_back();
		test_output_hold();
		test_sender_pause();

		wait_for_drain();
		// wait on to catch any stray result
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("lru_replacement_list_top_tb OK");
		else
			$display("lru_replacement_list_top_tb NOT OK");
		$finish;
	end

endmodule
